// ===== design/fir_window_filter_div_unit_defines.svh =====
// Assertion macros shared by the filter's RTL files.
// Depends on nothing; the bodies vanish when SYNTHESIS is defined.
`ifndef FIR_WINDOW_FILTER_DIV_UNIT_DEFINES_SVH
`define FIR_WINDOW_FILTER_DIV_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FWFD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fwfd assertion failed");
// Next-cycle implication.
`define FWFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fwfd assertion failed");
`else
`define FWFD_ASSERT_IMP(label, clk, rst, ante, cons)
`define FWFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/fwfd_pkg.sv =====
// Package of the windowed FIR filter with division: widths, types, codes.
// Used by every module of the block; depends on nothing.
package fwfd_pkg;

  localparam int MAX_TAPS  = 8;
  localparam int SAMPLE_W  = 8;
  localparam int COEF_W    = 64;
  localparam int DIV_W     = 16;
  localparam int TAPS_W    = 4;
  localparam int FILT_W    = 19;
  localparam int ACC_W     = 19;
  localparam int MAG_W     = 18;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int TAP_IDX_W = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
  localparam int BIT_CNT_W = $clog2(MAG_W);
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COEFFICIENTS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS_IN_USE  = CFG_IDX_W'(2);

  typedef logic [MAX_TAPS-1:0][SAMPLE_W-1:0] window_t;

  // One word handed from the front to the back: window snapshot and its length.
  typedef struct packed {
    window_t                window;
    logic [TAP_CNT_W-1:0]   ntaps;
  } entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MAC,
    BK_PREP,
    BK_DIV,
    BK_FIN,
    BK_DONE
  } back_state_e;

  // Clamp the configured tap count into 1..MAX_TAPS.
  function automatic logic [TAP_CNT_W-1:0] sat_taps(input logic [TAPS_W-1:0] n);
    logic [TAP_CNT_W-1:0] r;
    if (n == '0) begin
      r = TAP_CNT_W'(1);
    end else if (32'(n) > MAX_TAPS) begin
      r = TAP_CNT_W'(MAX_TAPS);
    end else begin
      r = TAP_CNT_W'(n);
    end
    return r;
  endfunction

endpackage

// ===== design/fwfd_front.sv =====
// Front of the filter: accepts samples and shifts them into the window.
// Depends on fwfd_pkg; pushes a window snapshot into fwfd_queue.
module fwfd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [fwfd_pkg::SAMPLE_W-1:0] sample,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [fwfd_pkg::TAPS_W-1:0]         taps_in_use,
  input  fwfd_pkg::q_status_t                 qst,
  output logic                                push,
  output fwfd_pkg::entry_t                    push_entry
);

  fwfd_pkg::window_t              window;
  fwfd_pkg::window_t              window_next;
  fwfd_pkg::window_t              shifted;
  logic [fwfd_pkg::TAP_CNT_W-1:0] ntaps;

  // A word is taken whenever the queue has room.
  assign sample_stall = qst.full;
  assign push         = sample_valid && !qst.full;
  assign ntaps        = fwfd_pkg::sat_taps(taps_in_use);

  // Positions below the newest used one take their upper neighbour; the newest
  // used position takes the sample; unused positions keep their contents.
  always_comb begin
    shifted = {{fwfd_pkg::SAMPLE_W{1'b0}}, window[fwfd_pkg::MAX_TAPS-1:1]};
    for (int i = 0; i < fwfd_pkg::MAX_TAPS; i++) begin
      if (fwfd_pkg::TAP_CNT_W'(i + 1) < ntaps) begin
        window_next[i] = shifted[i];
      end else if (fwfd_pkg::TAP_CNT_W'(i + 1) == ntaps) begin
        window_next[i] = sample;
      end else begin
        window_next[i] = window[i];
      end
    end
  end

  assign push_entry.window = window_next;
  assign push_entry.ntaps  = ntaps;

  // The window starts cleared to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (push) begin
      window <= window_next;
    end
  end

endmodule

// ===== design/fwfd_queue.sv =====
// Short queue of window snapshots between the front and the back.
// Depends on fwfd_pkg.
module fwfd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fwfd_pkg::entry_t    push_entry,
  input  logic                pop,
  output fwfd_pkg::entry_t    head,
  output fwfd_pkg::q_status_t qst
);

  fwfd_pkg::entry_t            slots [fwfd_pkg::QDEPTH];
  logic [fwfd_pkg::QPTR_W-1:0] wr_ptr;
  logic [fwfd_pkg::QPTR_W-1:0] rd_ptr;
  logic [fwfd_pkg::QCNT_W-1:0] count;

  assign qst.full  = (count == fwfd_pkg::QCNT_W'(fwfd_pkg::QDEPTH));
  assign qst.empty = (count == '0);
  assign head      = slots[rd_ptr];

  // Pointer advance with wrap at the queue depth.
  function automatic logic [fwfd_pkg::QPTR_W-1:0] bump(input logic [fwfd_pkg::QPTR_W-1:0] p);
    logic [fwfd_pkg::QPTR_W-1:0] r;
    if (p == fwfd_pkg::QPTR_W'(fwfd_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Slot storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/fwfd_back.sv =====
// Back of the filter: sequential multiply-accumulate, restoring division
// and the result register. Depends on fwfd_pkg; pops words from fwfd_queue.
module fwfd_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fwfd_pkg::q_status_t                   qst,
  input  fwfd_pkg::entry_t                      head,
  output logic                                  pop,
  input  logic [fwfd_pkg::COEF_W-1:0]           coefficients,
  input  logic signed [fwfd_pkg::DIV_W-1:0]     divisor,
  output logic signed [fwfd_pkg::FILT_W-1:0]    filtered,
  output logic                                  divide_error,
  output logic                                  result_valid,
  input  logic                                  result_stall
);

  fwfd_pkg::back_state_e            state;
  fwfd_pkg::back_state_e            state_next;
  fwfd_pkg::window_t                window;
  logic [fwfd_pkg::TAP_CNT_W-1:0]   ntaps;
  logic [fwfd_pkg::TAP_IDX_W-1:0]   k;
  logic signed [fwfd_pkg::ACC_W-1:0] acc;
  logic signed [fwfd_pkg::PROD_W-1:0] product;
  logic [fwfd_pkg::MAG_W-1:0]       dq;
  logic [fwfd_pkg::DIV_W-1:0]       rem;
  logic [fwfd_pkg::DIV_W-1:0]       dmag;
  logic [fwfd_pkg::DIV_W:0]         rem_sh;
  logic [fwfd_pkg::DIV_W:0]         rem_sub;
  logic                             ge;
  logic [fwfd_pkg::BIT_CNT_W-1:0]   bitcnt;
  logic                             neg;
  logic                             err;
  logic signed [fwfd_pkg::ACC_W-1:0] acc_abs;
  logic signed [fwfd_pkg::FILT_W-1:0] quot;
  logic                             last_tap;
  logic                             last_bit;

  // One tap product per cycle on the shared multiplier.
  assign product = $signed(window[k])
                 * $signed(coefficients[k * fwfd_pkg::SAMPLE_W +: fwfd_pkg::SAMPLE_W]);
  assign last_tap = (fwfd_pkg::TAP_CNT_W'(k) + 1'b1) == ntaps;

  // One quotient bit per cycle of the restoring division.
  assign rem_sh  = {rem, dq[fwfd_pkg::MAG_W-1]};
  assign ge      = rem_sh >= {1'b0, dmag};
  assign rem_sub = rem_sh - {1'b0, dmag};
  assign last_bit = bitcnt == fwfd_pkg::BIT_CNT_W'(fwfd_pkg::MAG_W - 1);

  assign acc_abs = acc[fwfd_pkg::ACC_W-1] ? -acc : acc;
  assign quot    = $signed({1'b0, dq});

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fwfd_pkg::BK_IDLE: begin
        if (!qst.empty) state_next = fwfd_pkg::BK_MAC;
      end
      fwfd_pkg::BK_MAC: begin
        if (last_tap) state_next = fwfd_pkg::BK_PREP;
      end
      fwfd_pkg::BK_PREP: begin
        state_next = (divisor == '0) ? fwfd_pkg::BK_FIN : fwfd_pkg::BK_DIV;
      end
      fwfd_pkg::BK_DIV: begin
        if (last_bit) state_next = fwfd_pkg::BK_FIN;
      end
      fwfd_pkg::BK_FIN: begin
        state_next = fwfd_pkg::BK_DONE;
      end
      fwfd_pkg::BK_DONE: begin
        if (!result_stall) state_next = fwfd_pkg::BK_IDLE;
      end
      default: state_next = fwfd_pkg::BK_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    pop          = 1'b0;
    result_valid = 1'b0;
    unique case (state)
      fwfd_pkg::BK_IDLE: pop = !qst.empty;
      fwfd_pkg::BK_DONE: result_valid = 1'b1;
      default: begin
        pop          = 1'b0;
        result_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fwfd_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers, loaded according to the current step.
  always_ff @(posedge clk) begin
    unique case (state)
      fwfd_pkg::BK_IDLE: begin
        window <= head.window;
        ntaps  <= head.ntaps;
        k      <= '0;
        acc    <= '0;
      end
      fwfd_pkg::BK_MAC: begin
        acc <= acc + fwfd_pkg::ACC_W'(product);
        k   <= k + 1'b1;
      end
      fwfd_pkg::BK_PREP: begin
        dq     <= acc_abs[fwfd_pkg::MAG_W-1:0];
        rem    <= '0;
        dmag   <= divisor[fwfd_pkg::DIV_W-1] ? fwfd_pkg::DIV_W'(-divisor) : divisor;
        neg    <= acc[fwfd_pkg::ACC_W-1] ^ divisor[fwfd_pkg::DIV_W-1];
        err    <= (divisor == '0);
        bitcnt <= '0;
      end
      fwfd_pkg::BK_DIV: begin
        rem    <= ge ? rem_sub[fwfd_pkg::DIV_W-1:0] : rem_sh[fwfd_pkg::DIV_W-1:0];
        dq     <= {dq[fwfd_pkg::MAG_W-2:0], ge};
        bitcnt <= bitcnt + 1'b1;
      end
      fwfd_pkg::BK_FIN: begin
        if (err) begin
          filtered <= '0;
        end else begin
          filtered <= neg ? -quot : quot;
        end
        divide_error <= err;
      end
      fwfd_pkg::BK_DONE: begin
        k <= k;
      end
      default: begin
        k <= k;
      end
    endcase
  end

endmodule

// ===== design/fir_window_filter_div_unit.sv =====
// Windowed FIR filter with signed division, one result word per sample word.
// Each accepted word passes through the shared multiply-accumulate over the taps
// in use, the 18-step divider (skipped for a zero divisor) and the result register.
// The back takes a new word only after its last result is taken; a two-deep queue
// lets the front take words while the back works or waits on a stalled result.
// Reset (rst, synchronous): window cleared, queue emptied, config and state to defaults.
`include "fir_window_filter_div_unit_defines.svh"
module fir_window_filter_div_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [fwfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fwfd_pkg::COEF_W-1:0]           cfg_data,
  input  logic signed [fwfd_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  output logic signed [fwfd_pkg::FILT_W-1:0]    filtered,
  output logic                                  divide_error,
  output logic                                  result_valid,
  input  logic                                  result_stall
);

  logic [fwfd_pkg::COEF_W-1:0]       coefficients;
  logic signed [fwfd_pkg::DIV_W-1:0] divisor;
  logic [fwfd_pkg::TAPS_W-1:0]       taps_in_use;
  logic                              push;
  logic                              pop;
  fwfd_pkg::entry_t                  push_entry;
  fwfd_pkg::entry_t                  head;
  fwfd_pkg::q_status_t               qst;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      coefficients <= '0;
      divisor      <= fwfd_pkg::DIV_W'(1);
      taps_in_use  <= fwfd_pkg::TAPS_W'(fwfd_pkg::MAX_TAPS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fwfd_pkg::CFG_COEFFICIENTS: coefficients <= cfg_data;
        fwfd_pkg::CFG_DIVISOR:      divisor      <= cfg_data[fwfd_pkg::DIV_W-1:0];
        fwfd_pkg::CFG_TAPS_IN_USE:  taps_in_use  <= cfg_data[fwfd_pkg::TAPS_W-1:0];
        default:                    coefficients <= coefficients;
      endcase
    end
  end

  fwfd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .taps_in_use  (taps_in_use),
    .qst          (qst),
    .push         (push),
    .push_entry   (push_entry)
  );

  fwfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qst        (qst)
  );

  fwfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qst          (qst),
    .head         (head),
    .pop          (pop),
    .coefficients (coefficients),
    .divisor      (divisor),
    .filtered     (filtered),
    .divide_error (divide_error),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  // A zero divisor always comes out as a zero result.
  `FWFD_ASSERT_IMP(a_err_gives_zero, clk, rst, result_valid && divide_error, filtered == '0)
  // An accepted word is waiting in the queue in the next cycle.
  `FWFD_ASSERT_NEXT(a_push_lands, clk, rst, sample_valid && !sample_stall, !qst.empty)
  // The queue can never look full and empty at once.
  `FWFD_ASSERT_IMP(a_queue_sane, clk, rst, 1'b1, !(qst.full && qst.empty))

endmodule
